>>> rtl/rlgr_pkg.sv
// Shared types and constants for the RLGR entropy encoder.
// Holds the item structs, the register index codes and the fixed field widths.
// No dependencies.
package rlgr_pkg;

  // Fixed widths that follow from the coding scheme
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CodeW   = 64;
  localparam int unsigned CountW  = 7;
  localparam int unsigned KW      = 5;   // run parameter, 0..16
  localparam int unsigned KrW     = 6;   // rice parameter, 0..32
  localparam int unsigned ZrcW    = 17;  // zero run counter, up to 2^16
  localparam int unsigned StepW   = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FifoD   = 3;   // most code fields one item can cause

  typedef struct packed {
    logic              kind;
    logic [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0]  code_bits;
    logic [CountW-1:0] bit_count;
    logic              last;
  } out_item_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIGNED_MODE       = 3'd0,
    CFG_RUN_UP_STEP       = 3'd1,
    CFG_RUN_DOWN_STEP     = 3'd2,
    CFG_FULL_RUN_UP_STEP  = 3'd3,
    CFG_RUN_END_DOWN_STEP = 3'd4
  } cfg_idx_e;

  // Item kinds
  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

endpackage

>>> rtl/rlgr_encoder.sv
// Top level of the RLGR entropy encoder: state, coding logic, field queue
// and output register. Depends on rlgr_pkg.
//
// The encoder takes one value (or a finish request) per item and codes it in a
// single registered pass: the run-length and Golomb-Rice fields, and the new
// run level, rice level and zero run count, are formed in the cycle the item
// is accepted. The fields (up to three: run-end head, unary part, residual or
// raw escape) go into a three-entry queue that drains one field per cycle into
// the output register whenever that register is empty or being taken. A new
// item is accepted once the queue is empty or its last field is leaving, so
// items flow back to back while the result side keeps taking fields; the
// one-field-per-cycle output channel sets the rate. The configuration registers
// are written through a plain write port and should only change while the
// encoder is idle.
module rlgr_encoder
  import rlgr_pkg::*;
#(
  parameter int unsigned SCALE = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [StepW-1:0]   cfg_data_i
);

  localparam int unsigned KMax     = 16;
  localparam int unsigned KrMax    = 32;
  localparam int unsigned RunCap   = KMax * SCALE;
  localparam int unsigned RiceCap  = KrMax * SCALE;
  localparam int unsigned RiceInit = 2 * SCALE;
  localparam int unsigned LW       = $clog2(RunCap + 1);
  localparam int unsigned RW       = $clog2(RiceCap + 1);

  // Configuration registers
  logic             signed_mode_q;
  logic [StepW-1:0] run_up_step_q, run_down_step_q;
  logic [StepW-1:0] full_run_up_step_q, run_end_down_step_q;

  // Adaptation state
  logic [LW-1:0]   run_level_q, run_level_d;
  logic [RW-1:0]   rice_level_q, rice_level_d;
  logic [ZrcW-1:0] zrc_q, zrc_d;

  // Field queue and output register
  out_item_t          st_q [FifoD];
  out_item_t          st_new [FifoD];
  logic [1:0]         n_q, n_new;
  logic               out_valid_q;
  out_item_t          out_q;
  logic               pop, in_fire;

  // Coding datapath
  logic [KW-1:0]     k;
  logic [KrW-1:0]    kr;
  logic [ValueW-1:0] u, ur, q;
  logic              esc, rice_b_vld, full;
  logic [CountW-1:0] un_len;
  out_item_t         rice_a, rice_b, head, zero_bit;
  logic [RW-1:0]     rice_adapt;
  logic [ValueW:0]   nb;
  logic [ZrcW-1:0]   zrc_inc;
  logic [LW:0]       rl_up, rl_full;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q       <= 1'b1;
      run_up_step_q       <= 4'd3;
      run_down_step_q     <= 4'd1;
      full_run_up_step_q  <= 4'd2;
      run_end_down_step_q <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIGNED_MODE:       signed_mode_q       <= cfg_data_i[0];
        CFG_RUN_UP_STEP:       run_up_step_q       <= cfg_data_i;
        CFG_RUN_DOWN_STEP:     run_down_step_q     <= cfg_data_i;
        CFG_FULL_RUN_UP_STEP:  full_run_up_step_q  <= cfg_data_i;
        CFG_RUN_END_DOWN_STEP: run_end_down_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Derive coding parameters: each level over SCALE, found by threshold compares
  always_comb begin
    k = '0;
    for (int unsigned i = 1; i <= KMax; i++) begin
      if (run_level_q >= LW'(i * SCALE)) k = KW'(i);
    end
  end

  always_comb begin
    kr = '0;
    for (int unsigned i = 1; i <= KrMax; i++) begin
      if (rice_level_q >= RW'(i * SCALE)) kr = KrW'(i);
    end
  end

  // Fold the value
  always_comb begin
    if (signed_mode_q && in_data_i.value[ValueW-1]) begin
      u = {~in_data_i.value[ValueW-2:0], 1'b1};
    end else if (signed_mode_q) begin
      u = {in_data_i.value[ValueW-2:0], 1'b0};
    end else begin
      u = in_data_i.value;
    end
  end

  // Golomb-Rice fields of the coded number
  assign ur         = (k == '0) ? u : u - 32'd1;
  assign q          = ur >> kr;
  assign esc        = |q[ValueW-1:6];
  assign un_len     = {1'b0, q[5:0]} + 7'd1;
  assign rice_b_vld = esc || (kr != '0);

  always_comb begin
    if (esc) begin
      rice_a = '{code_bits: '1, bit_count: 7'd64, last: 1'b0};
      rice_b = '{code_bits: {32'd0, ur}, bit_count: 7'd64, last: 1'b0};
    end else begin
      rice_a = '{code_bits: ((64'd1 << un_len) - 64'd1) & ~64'd1,
                 bit_count: un_len, last: 1'b0};
      rice_b = '{code_bits: {32'd0, ur} & ((64'd1 << kr) - 64'd1),
                 bit_count: CountW'(kr), last: 1'b0};
    end
  end

  // Adapt the rice level from the quotient
  assign nb = {1'b0, q} + (ValueW + 1)'(rice_level_q) - 33'd1;

  always_comb begin
    if (q == '0) begin
      rice_adapt = (rice_level_q < RW'(2)) ? '0 : rice_level_q - RW'(2);
    end else if (q > 32'd1) begin
      rice_adapt = (nb > (ValueW + 1)'(RiceCap)) ? RW'(RiceCap) : RW'(nb);
    end else begin
      rice_adapt = rice_level_q;
    end
  end

  // Run fields and run level steps
  assign zero_bit = '{code_bits: '0, bit_count: 7'd1, last: 1'b0};
  assign head     = '{code_bits: (64'd1 << k) | ({47'd0, zrc_q} & ((64'd1 << k) - 64'd1)),
                      bit_count: CountW'(k) + 7'd1, last: 1'b0};
  assign zrc_inc  = zrc_q + 17'd1;
  assign full     = (zrc_inc == (17'd1 << k));
  assign rl_up    = (LW + 1)'(run_level_q) + (LW + 1)'(run_up_step_q);
  assign rl_full  = (LW + 1)'(run_level_q) + (LW + 1)'(full_run_up_step_q);

  // Code one item: fields and next state
  always_comb begin
    n_new        = 2'd0;
    st_new[0]    = zero_bit;
    st_new[1]    = rice_a;
    st_new[2]    = rice_b;
    run_level_d  = run_level_q;
    rice_level_d = rice_level_q;
    zrc_d        = zrc_q;
    if (in_data_i.kind == KIND_FINISH) begin
      n_new        = (zrc_q != '0) ? 2'd1 : 2'd0;
      run_level_d  = '0;
      rice_level_d = RW'(RiceInit);
      zrc_d        = '0;
    end else if (k == '0) begin
      st_new[0]    = rice_a;
      st_new[1]    = rice_b;
      n_new        = rice_b_vld ? 2'd2 : 2'd1;
      rice_level_d = rice_adapt;
      zrc_d        = '0;
      if (u == '0) begin
        run_level_d = (rl_up > (LW + 1)'(RunCap)) ? LW'(RunCap) : LW'(rl_up);
      end else begin
        run_level_d = (run_level_q < LW'(run_down_step_q)) ? '0
                    : run_level_q - LW'(run_down_step_q);
      end
    end else if (u == '0) begin
      if (full) begin
        n_new       = 2'd1;
        zrc_d       = '0;
        run_level_d = (rl_full > (LW + 1)'(RunCap)) ? LW'(RunCap) : LW'(rl_full);
      end else begin
        zrc_d = zrc_inc;
      end
    end else begin
      st_new[0]    = head;
      n_new        = rice_b_vld ? 2'd3 : 2'd2;
      rice_level_d = rice_adapt;
      zrc_d        = '0;
      run_level_d  = (run_level_q > LW'(run_end_down_step_q))
                   ? run_level_q - LW'(run_end_down_step_q) : '0;
    end
    // Mark the final field of the item
    for (int i = 0; i < FifoD; i++) begin
      st_new[i].last = (2'(i) == n_new - 2'd1);
    end
  end

  // Handshake: move a field when the output register frees up
  assign pop        = (n_q != 2'd0) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (n_q == 2'd0) || ((n_q == 2'd1) && pop);
  assign in_fire    = in_valid_i && in_ready_o;

  // Hold adaptation state and queue fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_level_q  <= '0;
      rice_level_q <= RW'(RiceInit);
      zrc_q        <= '0;
      n_q          <= 2'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        run_level_q  <= run_level_d;
        rice_level_q <= rice_level_d;
        zrc_q        <= zrc_d;
        n_q          <= n_new;
      end else if (pop) begin
        n_q <= n_q - 2'd1;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load or advance the queue and the output payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      st_q <= st_new;
    end else if (pop) begin
      st_q[0] <= st_q[1];
      st_q[1] <= st_q[2];
    end
    if (pop) begin
      out_q <= st_q[0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Levels stay within their saturation bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_level_q <= LW'(RunCap)) && (rice_level_q <= RW'(RiceCap)))
    else $error("adaptation level beyond its cap");

  // A run never reaches its full length without being flushed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k != '0) |-> ({1'b0, zrc_q} < (18'd1 << k)))
    else $error("zero run count reached a full run");

  // Every delivered field carries at least one bit and at most 64
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.bit_count != '0) && (out_data_o.bit_count <= 7'd64))
    else $error("output field with bad bit count");

  // A finish item restarts the adaptation state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.kind == KIND_FINISH)) |=>
      (run_level_q == '0) && (zrc_q == '0) && (rice_level_q == RW'(RiceInit)))
    else $error("state not reinitialized after finish");

endmodule

>>> sim/rlgr_encoder_test.sv
// Self-checking testbench for the RLGR entropy encoder: a code tracker class
// that mirrors the coder state and checks each code field, plus driving tasks.
// Depends on rlgr_pkg and rlgr_encoder.
`timescale 1ns / 1ps

import rlgr_pkg::*;

// Mirrors the encoder state and registers, predicts the code fields of each
// accepted item and matches them against the fields the encoder sends.
class rlgr_code_tracker #(int unsigned Scale = 4);
  logic                  signed_mode;
  logic [StepW-1:0]      run_up_step;
  logic [StepW-1:0]      run_down_step;
  logic [StepW-1:0]      full_run_up_step;
  logic [StepW-1:0]      run_end_down_step;
  logic [6:0]            run_level;
  logic [7:0]            rice_level;
  logic [ZrcW-1:0]       zero_run;
  out_item_t             pending_fields[$];
  out_item_t             item_fields[$];
  int unsigned           errors;
  int unsigned           n_values;
  int unsigned           n_finishes;
  int unsigned           n_fields;
  int unsigned           n_escapes;
  int unsigned           n_full_runs;
  int unsigned           n_run_ends;
  int unsigned           n_flushes;
  int unsigned           max_k;

  function new();
    signed_mode       = 1'b1;
    run_up_step       = 4'd3;
    run_down_step     = 4'd1;
    full_run_up_step  = 4'd2;
    run_end_down_step = 4'd1;
    restart();
    errors      = 0;
    n_values    = 0;
    n_finishes  = 0;
    n_fields    = 0;
    n_escapes   = 0;
    n_full_runs = 0;
    n_run_ends  = 0;
    n_flushes   = 0;
    max_k       = 0;
  endfunction

  function void restart();
    run_level  = '0;
    rice_level = 8'(2 * Scale);
    zero_run   = '0;
  endfunction

  function int unsigned outstanding();
    return pending_fields.size();
  endfunction

  // Apply a register write; unknown indexes drop, upper data bits drop for the signed mode
  function void write_reg(logic [CfgIdxW-1:0] idx, logic [StepW-1:0] data);
    case (idx)
      CFG_SIGNED_MODE:       signed_mode       = data[0];
      CFG_RUN_UP_STEP:       run_up_step       = data;
      CFG_RUN_DOWN_STEP:     run_down_step     = data;
      CFG_FULL_RUN_UP_STEP:  full_run_up_step  = data;
      CFG_RUN_END_DOWN_STEP: run_end_down_step = data;
      default: ;
    endcase
  endfunction

  function logic [CodeW-1:0] lo_mask(int unsigned w);
    if (w >= CodeW) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  // Add one field to the current item; zero-width fields vanish
  function void push_field(logic [CodeW-1:0] bits, int unsigned count);
    out_item_t f;
    if (count == 0) return;
    f.code_bits = bits & lo_mask(count);
    f.bit_count = CountW'(count);
    f.last      = 1'b0;
    item_fields.push_back(f);
  endfunction

  function logic [6:0] cap_run(int unsigned lvl);
    return (lvl > 16 * Scale) ? 7'(16 * Scale) : 7'(lvl);
  endfunction

  // Golomb-Rice code: unary quotient and residual, or the escape form
  function void code_rice(logic [CodeW-1:0] u, int unsigned kr);
    logic [CodeW-1:0] q;
    q = u >> kr;
    if (q < 64) begin
      push_field(~64'd1, int'(q) + 1);
      push_field(u, kr);
    end else begin
      n_escapes++;
      push_field('1, CodeW);
      push_field(u, CodeW);
    end
  endfunction

  function void adapt_rice(logic [CodeW-1:0] u, int unsigned kr);
    logic [CodeW-1:0] q;
    logic [CodeW-1:0] grown;
    q = u >> kr;
    if (q == 0) begin
      rice_level = (rice_level < 2) ? '0 : rice_level - 8'd2;
    end else if (q > 1) begin
      grown      = rice_level + q - 1;
      rice_level = (grown > 32 * Scale) ? 8'(32 * Scale) : 8'(grown);
    end
  endfunction

  // Work out the code fields of one accepted item and queue them
  function void code_item(in_item_t it);
    int unsigned      k;
    int unsigned      kr;
    int unsigned      lvl;
    logic [CodeW-1:0] u;
    logic [CodeW-1:0] head;
    out_item_t        f;
    item_fields.delete();
    if (it.kind == KIND_FINISH) begin
      n_finishes++;
      if (zero_run != 0) begin
        n_flushes++;
        push_field('0, 1);
      end
      restart();
    end else begin
      n_values++;
      k  = run_level / Scale;
      kr = rice_level / Scale;
      if (k > max_k) max_k = k;
      // fold signed input: v >= 0 to 2v, v < 0 to 2|v|-1
      if (signed_mode && it.value[ValueW-1]) begin
        u = ((64'h1_0000_0000 - {32'h0, it.value}) << 1) - 64'd1;
      end else if (signed_mode) begin
        u = {32'h0, it.value} << 1;
      end else begin
        u = {32'h0, it.value};
      end
      if (k == 0) begin
        code_rice(u, kr);
        adapt_rice(u, kr);
        if (u == 0) begin
          lvl       = run_level + run_up_step;
          run_level = cap_run(lvl);
        end else begin
          run_level = (run_level < run_down_step) ? '0 : run_level - run_down_step;
        end
        zero_run = '0;
      end else if (u == 0) begin
        // extend the run; only a complete run sends a bit
        zero_run++;
        if (zero_run == (ZrcW'(1) << k)) begin
          n_full_runs++;
          push_field('0, 1);
          lvl       = run_level + full_run_up_step;
          run_level = cap_run(lvl);
          zero_run  = '0;
        end
      end else begin
        // end the run: flag bit and run length, then the value less one
        n_run_ends++;
        head = (64'd1 << k) | ({{(CodeW-ZrcW){1'b0}}, zero_run} & lo_mask(k));
        push_field(head, k + 1);
        code_rice(u - 64'd1, kr);
        adapt_rice(u - 64'd1, kr);
        run_level = (run_level > run_end_down_step) ? run_level - run_end_down_step : '0;
        zero_run  = '0;
      end
    end
    if (item_fields.size() != 0) begin
      f      = item_fields.pop_back();
      f.last = 1'b1;
      item_fields.push_back(f);
    end
    foreach (item_fields[i]) pending_fields.push_back(item_fields[i]);
    n_fields += item_fields.size();
  endfunction

  // Check one sent field against the oldest predicted one
  function void match_field(out_item_t got);
    out_item_t want;
    if (pending_fields.size() == 0) begin
      $error("unexpected code field: code_bits=%h bit_count=%0d last=%0b",
             got.code_bits, got.bit_count, got.last);
      errors++;
      return;
    end
    want = pending_fields.pop_front();
    if (got.code_bits !== want.code_bits) begin
      $error("code_bits: expected %h, actual %h", want.code_bits, got.code_bits);
      errors++;
    end
    if (got.bit_count !== want.bit_count) begin
      $error("bit_count: expected %0d, actual %0d", want.bit_count, got.bit_count);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, actual %0b", want.last, got.last);
      errors++;
    end
  endfunction
endclass

module rlgr_encoder_test;

  localparam int unsigned EncScale  = 4;
  localparam int unsigned DrainTail = 8;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [StepW-1:0]    cfg_data;
  logic                calm;

  rlgr_code_tracker #(EncScale) tracker;

  rlgr_encoder #(.SCALE(EncScale)) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("rlgr_encoder verification failed");
    $finish;
  end

  // Watch all three ports at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tracker.write_reg(cfg_idx, cfg_data);
      if (in_valid && in_ready) tracker.code_item(in_data);
      if (out_valid && out_ready) tracker.match_field(out_data);
    end
  end

  // Result side: random stall bursts, none once calm is set
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  function automatic in_item_t pack_item(logic kind, logic [ValueW-1:0] value);
    in_item_t it;
    it.kind  = kind;
    it.value = value;
    return it;
  endfunction

  function automatic int unsigned next_gap();
    if (calm || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 15);
  endfunction

  // Mostly zeros and small values so runs form, with some wide values and finish items
  function automatic in_item_t rand_item(int unsigned zero_pct);
    in_item_t    it;
    int unsigned pick;
    pick     = $urandom_range(0, 99);
    it.kind  = KIND_VALUE;
    it.value = $urandom();
    if (pick < 4) begin
      it.kind = KIND_FINISH;
    end else if (pick < 4 + zero_pct) begin
      it.value = '0;
    end else if (pick < 4 + zero_pct + (96 - zero_pct) / 2) begin
      it.value = $urandom_range(1, 9);
      if ($urandom_range(0, 1) == 1) it.value = -it.value;
    end else if (pick < 96) begin
      it.value = $urandom_range(1, 4095);
      if ($urandom_range(0, 1) == 1) it.value = -it.value;
    end
    return it;
  endfunction

  // Hold valid with the item until accepted, after an optional gap
  task automatic send_item(input in_item_t it, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned count, input int unsigned zero_pct);
    repeat (count) send_item(rand_item(zero_pct), next_gap());
  endtask

  // Stop sending, wait for every predicted field, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (DrainTail) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [StepW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [StepW-1:0] sm_word, input logic [StepW-1:0] up,
                              input logic [StepW-1:0] down, input logic [StepW-1:0] full_up,
                              input logic [StepW-1:0] end_down);
    write_reg(CFG_SIGNED_MODE, sm_word);
    write_reg(CFG_RUN_UP_STEP, up);
    write_reg(CFG_RUN_DOWN_STEP, down);
    write_reg(CFG_FULL_RUN_UP_STEP, full_up);
    write_reg(CFG_RUN_END_DOWN_STEP, end_down);
    cfg_we <= 1'b0;
  endtask

  initial begin
    tracker  = new();
    calm     = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_SIGNED_MODE;
    cfg_data = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part on the reset register values
    send_item(pack_item(KIND_FINISH, 32'hFFFF_FFFF), next_gap()); // nothing pending
    send_item(pack_item(KIND_VALUE, 32'd1), next_gap());
    send_item(pack_item(KIND_VALUE, 32'hFFFF_FFFF), next_gap());
    send_item(pack_item(KIND_VALUE, 32'hFFFF_FFFF), next_gap());
    send_item(pack_item(KIND_VALUE, 32'd1), next_gap());          // no residual field
    send_item(pack_item(KIND_VALUE, 32'h7FFF_FFFF), next_gap());  // escape
    send_item(pack_item(KIND_VALUE, 32'h8000_0000), next_gap());
    send_item(pack_item(KIND_VALUE, 32'h0), next_gap());
    send_item(pack_item(KIND_VALUE, 32'h0), next_gap());          // enter run mode
    send_item(pack_item(KIND_VALUE, 32'h0), next_gap());          // zero inside run
    send_item(pack_item(KIND_VALUE, 32'h0), next_gap());          // full run
    send_item(pack_item(KIND_VALUE, 32'h0), next_gap());
    send_item(pack_item(KIND_FINISH, 32'h0), next_gap());         // flush partial run
    send_item(pack_item(KIND_VALUE, 32'h0), next_gap());
    send_item(pack_item(KIND_VALUE, 32'h0), next_gap());
    send_item(pack_item(KIND_VALUE, 32'h0), next_gap());
    send_item(pack_item(KIND_VALUE, 32'hFFFF_FFFE), next_gap());  // run ended by nonzero
    send_item(pack_item(KIND_VALUE, 32'h8000_0000), next_gap());
    send_item(pack_item(KIND_VALUE, 32'h5555_5555), next_gap());
    send_item(pack_item(KIND_VALUE, 32'hAAAA_AAAA), next_gap());
    send_item(pack_item(KIND_FINISH, 32'h0), next_gap());
    send_random(22, 41);

    // Unsigned through upper data bits, all steps at minimum, stray indexes
    wait_drained();
    for (int i = int'(CFG_RUN_END_DOWN_STEP) + 1; i < (1 << CfgIdxW); i++) begin
      write_reg(CfgIdxW'(i), StepW'($urandom_range(0, 15)));
    end
    program_regs(4'b1110, 4'd0, 4'd0, 4'd0, 4'd0);
    send_random(30, 41);

    // Signed, all steps at maximum, zero heavy to push the run parameter up
    wait_drained();
    program_regs(4'b0001, 4'd15, 4'd15, 4'd15, 4'd15);
    send_random(30, 70);

    // Unsigned, random steps, with a full drain halfway
    wait_drained();
    program_regs(4'b0000, StepW'($urandom_range(0, 15)), StepW'($urandom_range(0, 15)),
                 StepW'($urandom_range(0, 15)), StepW'($urandom_range(0, 15)));
    send_random(15, 41);
    wait_drained();
    send_random(15, 41);

    // Signed, random steps
    wait_drained();
    program_regs(4'b1111, StepW'($urandom_range(0, 15)), StepW'($urandom_range(0, 15)),
                 StepW'($urandom_range(0, 15)), StepW'($urandom_range(0, 15)));
    send_random(30, 55);

    // Back to reset values, no idling on either side
    wait_drained();
    program_regs(4'b0001, 4'd3, 4'd1, 4'd2, 4'd1);
    calm = 1'b1;
    send_random(30, 41);
    wait_drained();

    $display("Coded %0d values and %0d finishes (%0d flushed a run) into %0d fields.",
             tracker.n_values, tracker.n_finishes, tracker.n_flushes, tracker.n_fields);
    $display("Saw %0d escapes, %0d full runs, %0d run ends; run parameter reached %0d.",
             tracker.n_escapes, tracker.n_full_runs, tracker.n_run_ends, tracker.max_k);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("rlgr_encoder verification clean");
    end else begin
      $display("rlgr_encoder verification failed");
    end
    $finish;
  end

endmodule
